/* design/jtok_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character constants and helper functions for the JSON tokenizer.
// No dependencies; imported by jtok_lexer, jtok_queue and json_tokenizer.

package jtok_pkg;

    // Width of the line counter and of the line_number port
    localparam int LINE_BITS = 24;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BARE = 3'd1,
        MODE_STR  = 3'd2,
        MODE_ESC  = 3'd3,
        MODE_HEX  = 3'd4
    } jtok_mode_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2,
        KIND_DOC  = 2'd3
    } jtok_kind_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_ESCAPE = 2'd0,
        ERR_HEX    = 2'd1,
        ERR_OPEN   = 2'd2
    } jtok_err_t;

    // Character constants
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BS     = 8'h08;

    // One result transaction
    typedef struct packed {
        logic [1:0]           kind;
        logic [15:0]          code_unit;
        logic                 in_string;
        logic [1:0]           error_code;
        logic [LINE_BITS-1:0] line_number;
        logic                 last_of_run;
    } jtok_res_t;

    // All results caused by one input byte (up to three)
    typedef struct packed {
        logic [1:0]           count;
        jtok_res_t [2:0]      res;
    } jtok_bundle_t;

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_COLON) || (c == CH_COMMA) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Returns {valid, value}; accepts 0-9, A-F and a-f
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic jtok_res_t mk_res(input logic [1:0] kind, input logic [15:0] cu,
                                         input logic ins, input logic [1:0] err);
        jtok_res_t r;
        r             = '0;
        r.kind        = kind;
        r.code_unit   = cu;
        r.in_string   = ins;
        r.error_code  = err;
        return r;
    endfunction

endpackage

/* design/jtok_lexer.sv */
`timescale 1ns / 1ps
// Lexer state and next-state logic: turns one accepted byte into a bundle of
// up to three results. Depends on jtok_pkg.

module jtok_lexer
    import jtok_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [7:0]   text_byte,
    input  logic         end_of_text,
    output jtok_bundle_t bundle
);

    jtok_mode_t           mode_reg, mode_next;
    logic [1:0]           hex_cnt_reg, hex_cnt_next;
    logic [11:0]          hex_acc_reg, hex_acc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    // Next state and results for the byte on the input
    always_comb begin
        logic [LINE_BITS-1:0] line_bump;
        logic [LINE_BITS-1:0] line_shown;
        logic [4:0]           hd;
        logic [1:0]           cnt;
        jtok_res_t [2:0]      r;

        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        cnt          = 2'd0;
        r            = '0;
        hd           = hex_digit(text_byte);

        // Line count saturates at all ones
        line_bump = line_reg;
        if (text_byte == CH_LF && line_reg != {LINE_BITS{1'b1}}) begin
            line_bump = line_reg + LINE_BITS'(1);
        end

        if (end_of_text) begin
            line_shown = line_reg;
            line_next  = LINE_BITS'(1);
            if (mode_reg == MODE_BARE) begin
                r[0] = mk_res(KIND_END, 16'd0, 1'b0, ERR_ESCAPE);
                r[1] = mk_res(KIND_DOC, 16'd0, 1'b0, ERR_ESCAPE);
                cnt  = 2'd2;
            end else if (mode_reg == MODE_STR || mode_reg == MODE_ESC ||
                         mode_reg == MODE_HEX) begin
                r[0] = mk_res(KIND_ERR, 16'd0, 1'b1, ERR_OPEN);
                r[1] = mk_res(KIND_DOC, 16'd0, 1'b0, ERR_ESCAPE);
                cnt  = 2'd2;
            end else begin
                r[0] = mk_res(KIND_DOC, 16'd0, 1'b0, ERR_ESCAPE);
                cnt  = 2'd1;
            end
            mode_next    = MODE_IDLE;
            hex_cnt_next = 2'd0;
            hex_acc_next = 12'd0;
        end else begin
            line_shown = line_bump;
            line_next  = line_bump;
            unique case (mode_reg)
                MODE_BARE: begin
                    if (is_space(text_byte)) begin
                        r[0]      = mk_res(KIND_END, 16'd0, 1'b0, ERR_ESCAPE);
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                    end else if (is_single(text_byte)) begin
                        r[0]      = mk_res(KIND_END, 16'd0, 1'b0, ERR_ESCAPE);
                        r[1]      = mk_res(KIND_CHAR, {8'd0, text_byte}, 1'b0, ERR_ESCAPE);
                        r[2]      = mk_res(KIND_END, 16'd0, 1'b0, ERR_ESCAPE);
                        cnt       = 2'd3;
                        mode_next = MODE_IDLE;
                    end else if (text_byte == CH_QUOTE) begin
                        // bare token turns into a string token
                        mode_next = MODE_STR;
                    end else begin
                        r[0] = mk_res(KIND_CHAR, {8'd0, text_byte}, 1'b0, ERR_ESCAPE);
                        cnt  = 2'd1;
                    end
                end
                MODE_STR: begin
                    if (text_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else if (text_byte == CH_QUOTE) begin
                        r[0]      = mk_res(KIND_END, 16'd0, 1'b1, ERR_ESCAPE);
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        r[0] = mk_res(KIND_CHAR, {8'd0, text_byte}, 1'b1, ERR_ESCAPE);
                        cnt  = 2'd1;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_STR;
                    cnt       = 2'd1;
                    case (text_byte)
                        CH_BSLASH: r[0] = mk_res(KIND_CHAR, {8'd0, CH_BSLASH}, 1'b1, ERR_ESCAPE);
                        CH_QUOTE:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_QUOTE}, 1'b1, ERR_ESCAPE);
                        CH_SLASH:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_SLASH}, 1'b1, ERR_ESCAPE);
                        CH_LOW_B:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_BS}, 1'b1, ERR_ESCAPE);
                        CH_LOW_N:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_LF}, 1'b1, ERR_ESCAPE);
                        CH_LOW_R:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_CR}, 1'b1, ERR_ESCAPE);
                        CH_LOW_T:  r[0] = mk_res(KIND_CHAR, {8'd0, CH_TAB}, 1'b1, ERR_ESCAPE);
                        CH_LOW_U: begin
                            cnt          = 2'd0;
                            hex_cnt_next = 2'd0;
                            hex_acc_next = 12'd0;
                            mode_next    = MODE_HEX;
                        end
                        default: begin
                            r[0]      = mk_res(KIND_ERR, 16'd0, 1'b1, ERR_ESCAPE);
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!hd[4]) begin
                        r[0]      = mk_res(KIND_ERR, 16'd0, 1'b1, ERR_HEX);
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                    end else if (hex_cnt_reg == 2'd3) begin
                        // fourth digit completes the code unit
                        r[0]         = mk_res(KIND_CHAR, {hex_acc_reg, hd[3:0]}, 1'b1,
                                              ERR_ESCAPE);
                        cnt          = 2'd1;
                        hex_cnt_next = 2'd0;
                        hex_acc_next = 12'd0;
                        mode_next    = MODE_STR;
                    end else begin
                        hex_acc_next = {hex_acc_reg[7:0], hd[3:0]};
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
                default: begin
                    // between tokens
                    if (is_space(text_byte)) begin
                        cnt = 2'd0;
                    end else if (is_single(text_byte)) begin
                        r[0] = mk_res(KIND_CHAR, {8'd0, text_byte}, 1'b0, ERR_ESCAPE);
                        r[1] = mk_res(KIND_END, 16'd0, 1'b0, ERR_ESCAPE);
                        cnt  = 2'd2;
                    end else if (text_byte == CH_QUOTE) begin
                        mode_next = MODE_STR;
                    end else begin
                        r[0]      = mk_res(KIND_CHAR, {8'd0, text_byte}, 1'b0, ERR_ESCAPE);
                        cnt       = 2'd1;
                        mode_next = MODE_BARE;
                    end
                end
            endcase
            // errors drop any partial escape
            if (mode_next == MODE_IDLE) begin
                hex_cnt_next = 2'd0;
                hex_acc_next = 12'd0;
            end
        end

        // Stamp line numbers and mark the last result of the run
        for (int i = 0; i < 3; i++) begin
            r[i].line_number = line_shown;
        end
        case (cnt)
            2'd1:    r[0].last_of_run = 1'b1;
            2'd2:    r[1].last_of_run = 1'b1;
            2'd3:    r[2].last_of_run = 1'b1;
            default: ;
        endcase

        bundle.count = cnt;
        bundle.res   = r;
    end

    // State registers, updated on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            hex_acc_reg <= 12'd0;
            line_reg    <= LINE_BITS'(1);
        end else if (accept) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
            line_reg    <= line_next;
        end
    end

`ifndef SYNTH
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter reached zero");

    a_hex_only_in_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        (hex_cnt_reg != 2'd0) |-> (mode_reg == MODE_HEX))
        else $error("hex digit count outside of a \\u escape");

    a_eot_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && end_of_text) |=> (line_reg == LINE_BITS'(1) && mode_reg == MODE_IDLE))
        else $error("end of text did not return the lexer to its reset state");
`endif

endmodule

/* design/jtok_queue.sv */
`timescale 1ns / 1ps
// Two-deep bundle buffer that serializes each bundle into single result
// transactions. Depends on jtok_pkg.

module jtok_queue
    import jtok_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  jtok_bundle_t bundle,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output jtok_res_t    out_res
);

    logic         head_valid_reg, spare_valid_reg;
    jtok_bundle_t head_reg, spare_reg;
    logic [1:0]   idx_reg;
    logic         take, pop;

    assign in_ready  = !spare_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_res   = head_reg.res[idx_reg];
    assign take      = head_valid_reg && out_ready;
    assign pop       = take && (idx_reg == head_reg.count - 2'd1);

    // Control: valid flags and the result index within the head bundle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
            idx_reg         <= 2'd0;
        end else begin
            if (pop) begin
                idx_reg <= 2'd0;
                if (spare_valid_reg) begin
                    spare_valid_reg <= 1'b0;
                end else begin
                    head_valid_reg <= push;
                end
            end else begin
                if (take) begin
                    idx_reg <= idx_reg + 2'd1;
                end
                if (push) begin
                    if (head_valid_reg) begin
                        spare_valid_reg <= 1'b1;
                    end else begin
                        head_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload: bundles move without reset
    always_ff @(posedge aclk) begin
        if (pop && spare_valid_reg) begin
            head_reg <= spare_reg;
        end else if (push && (pop || !head_valid_reg)) begin
            head_reg <= bundle;
        end
        if (push && head_valid_reg && !pop) begin
            spare_reg <= bundle;
        end
    end

`ifndef SYNTH
    a_spare_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> head_valid_reg)
        else $error("spare bundle held without a head bundle");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg |-> (idx_reg < head_reg.count))
        else $error("result index past end of head bundle");

    a_no_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg |-> (head_reg.count != 2'd0))
        else $error("empty bundle stored in queue");
`endif

endmodule

/* design/json_tokenizer.sv */
`timescale 1ns / 1ps
// JSON tokenizer: one byte of text in, token characters and markers out.
// Channels: s_* takes a text byte or an end-of-text mark per transaction;
//   m_* delivers one result per transaction (token character, token end,
//   error or document end), last_of_run set on the last result of a byte.
// First result: valid in the cycle after the byte is accepted when the buffer
//   is empty; otherwise the bundle waits in the buffer. Bytes that cause no
//   result (whitespace between tokens, opening quote, backslash, first three hex digits) leave no trace.
// Throughput: one byte per cycle while each byte yields at most one result
//   and m_ready is high. A byte with several results holds the output until
//   each has been taken; the second bundle slot takes one more result-bearing
//   byte meanwhile. s_ready drops only when both slots are full.
// Reset (aresetn low, synchronous): lexer between tokens, line counter 1,
//   buffer empty. End of text also returns the lexer to this state.
// Stall: with m_ready low the current result holds steady; at most one
//   more byte's bundle is taken in before s_ready goes low.
// Depends on jtok_pkg, jtok_lexer and jtok_queue.

module json_tokenizer
    import jtok_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_of_text,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [15:0]          m_code_unit,
    output logic                 m_in_string,
    output logic [1:0]           m_error_code,
    output logic [LINE_BITS-1:0] m_line_number,
    output logic                 m_last_of_run
);

    logic         accept;
    jtok_bundle_t bundle;
    jtok_res_t    res;

    assign accept = s_valid && s_ready;

    jtok_lexer u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .text_byte   (s_text_byte),
        .end_of_text (s_end_of_text),
        .bundle      (bundle)
    );

    jtok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && (bundle.count != 2'd0)),
        .bundle    (bundle),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    // Result fields
    assign m_kind        = res.kind;
    assign m_code_unit   = res.code_unit;
    assign m_in_string   = res.in_string;
    assign m_error_code  = res.error_code;
    assign m_line_number = res.line_number;
    assign m_last_of_run = res.last_of_run;

endmodule
